[hw/rtl/twlc_pkg.sv]
// Shared types, constants and address helpers for the two-way LRU cache controller.
package twlc_pkg;

    localparam int SET_COUNT   = 4;
    localparam int LINE_WORDS  = 4;
    localparam int ADDR_BITS   = 16;
    localparam int NUM_WAYS    = 2;
    localparam int FILL_FIELDS = 4;

    localparam int OFF_W   = $clog2(LINE_WORDS);
    localparam int SET_W   = $clog2(SET_COUNT);
    localparam int TAG_W   = ADDR_BITS - OFF_W - SET_W;
    localparam int LINE_W  = SET_W + 1;
    localparam int NUM_LINES = SET_COUNT * NUM_WAYS;
    localparam int FILL_IDX_W = $clog2(FILL_FIELDS);

    localparam int WORD_W = 32;
    localparam int PEN_W  = 4;
    localparam int LAT_W  = 5;
    localparam int CNT_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic [PEN_W-1:0] PENALTY_RESET = 4'd3;

    // Register index of the configuration port (byte address / 4).
    localparam logic REG_MISS_PENALTY = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STORE = 2'd1,
        OP_FLUSH = 2'd2
    } t_op;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [ADDR_BITS-1:0]     t_addr;

    // One accepted request word, as held in the input register.
    typedef struct packed {
        logic [1:0]                 op;
        t_addr                      address;
        t_word                      store_value;
        t_word [FILL_FIELDS-1:0]    fill;
    } t_req;

    // One result word, as held in the output register.
    typedef struct packed {
        logic               stalled;
        t_word              load_data;
        logic               was_hit;
        logic [LAT_W-1:0]   latency;
        logic               fill_taken;
        logic               mem_write_valid;
        t_addr              mem_write_address;
        t_word              mem_write_value;
        logic [CNT_W-1:0]   hit_count;
        logic [CNT_W-1:0]   miss_count;
    } t_result;

    // Tag lookup answer from the line arrays.
    typedef struct packed {
        logic   hit;
        logic   hit_way;
        logic   victim_way;
        t_word  hit_word;
    } t_lookup;

    // Update command to the line arrays.
    typedef struct packed {
        logic   flush;
        logic   fill;
        logic   word_wr;
        logic   lru_wr;
        logic   way;
    } t_arr_cmd;

    function automatic logic [OFF_W-1:0] addr_offset(input t_addr a);
        return a[OFF_W-1:0];
    endfunction

    function automatic logic [SET_W-1:0] addr_set(input t_addr a);
        return a[OFF_W +: SET_W];
    endfunction

    function automatic logic [TAG_W-1:0] addr_tag(input t_addr a);
        return a[ADDR_BITS-1 -: TAG_W];
    endfunction

endpackage

[hw/rtl/twlc_apb.sv]
// Configuration register file behind the APB-style port.
module twlc_apb import twlc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [PEN_W-1:0]   o_miss_penalty
);

    logic [PEN_W-1:0] r_penalty;
    logic             w_reg_idx;

    assign w_reg_idx = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_penalty <= PENALTY_RESET;
        end else if (psel && penable && pwrite && (w_reg_idx == REG_MISS_PENALTY)) begin
            r_penalty <= pwdata[PEN_W-1:0];
        end
    end

    // Byte lanes below the word boundary are ignored.
    always_comb begin
        prdata = '0;
        if (w_reg_idx == REG_MISS_PENALTY) begin
            prdata = {{(32-PEN_W){1'b0}}, r_penalty};
        end
    end

    assign o_miss_penalty = r_penalty;

endmodule

[hw/rtl/twlc_array.sv]
// Tag, valid, LRU and data arrays with the two-way tag compare.
module twlc_array import twlc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_addr                   i_address,
    input  t_word                   i_store_value,
    input  t_word [FILL_FIELDS-1:0] i_fill,
    input  t_arr_cmd                i_cmd,
    output t_lookup                 o_lookup
);

    logic                  r_valid  [NUM_LINES];
    logic [TAG_W-1:0]      r_tag    [NUM_LINES];
    logic                  r_recent [SET_COUNT];
    t_word                 r_words  [NUM_LINES][LINE_WORDS];

    logic [OFF_W-1:0]  w_off;
    logic [SET_W-1:0]  w_set;
    logic [TAG_W-1:0]  w_tag;
    logic [LINE_W-1:0] w_line0;
    logic [LINE_W-1:0] w_line1;
    logic [LINE_W-1:0] w_upd_line;
    logic              w_hit0;
    logic              w_hit1;

    assign w_off   = addr_offset(i_address);
    assign w_set   = addr_set(i_address);
    assign w_tag   = addr_tag(i_address);
    assign w_line0 = {w_set, 1'b0};
    assign w_line1 = {w_set, 1'b1};
    assign w_upd_line = {w_set, i_cmd.way};

    assign w_hit0 = r_valid[w_line0] && (r_tag[w_line0] == w_tag);
    assign w_hit1 = r_valid[w_line1] && (r_tag[w_line1] == w_tag);

    always_comb begin
        o_lookup.hit      = w_hit0 || w_hit1;
        o_lookup.hit_way  = !w_hit0;
        // Empty way first (way 0 before way 1), else the least recently used way.
        if (!r_valid[w_line0]) begin
            o_lookup.victim_way = 1'b0;
        end else if (!r_valid[w_line1]) begin
            o_lookup.victim_way = 1'b1;
        end else begin
            o_lookup.victim_way = !r_recent[w_set];
        end
        o_lookup.hit_word = r_words[{w_set, !w_hit0}][w_off];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                r_valid[i] <= 1'b0;
            end
            for (int s = 0; s < SET_COUNT; s++) begin
                r_recent[s] <= 1'b0;
            end
        end else if (i_cmd.flush) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                r_valid[i] <= 1'b0;
            end
            for (int s = 0; s < SET_COUNT; s++) begin
                r_recent[s] <= 1'b0;
            end
        end else begin
            if (i_cmd.fill) begin
                r_valid[w_upd_line] <= 1'b1;
            end
            if (i_cmd.lru_wr) begin
                r_recent[w_set] <= i_cmd.way;
            end
        end
    end

    // Tags and words are only read through a valid line, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_tag[w_upd_line] <= w_tag;
            for (int i = 0; i < LINE_WORDS; i++) begin
                if (i < FILL_FIELDS) begin
                    r_words[w_upd_line][i] <= i_fill[i];
                end else begin
                    r_words[w_upd_line][i] <= '0;
                end
            end
        end
        if (i_cmd.word_wr) begin
            r_words[w_upd_line][w_off] <= i_store_value;
        end
    end

endmodule

[hw/rtl/twlc_ctrl.sv]
// Access control: stall countdown, pending flags, hit and miss totals, result forming.
module twlc_ctrl import twlc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  t_req             i_req,
    input  logic [PEN_W-1:0] i_miss_penalty,
    input  t_lookup          i_lookup,
    output t_arr_cmd         o_cmd,
    output t_result          o_res
);

    logic [PEN_W-1:0] r_countdown;
    logic             r_load_pending;
    logic             r_store_pending;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;

    logic [PEN_W-1:0] n_countdown;
    logic             n_load_pending;
    logic             n_store_pending;
    logic [CNT_W-1:0] n_hits;
    logic [CNT_W-1:0] n_misses;

    t_arr_cmd         w_cmd;
    logic [OFF_W-1:0] w_off;
    t_word            w_fill_word;
    logic [LAT_W-1:0] w_slow_lat;

    assign w_off      = addr_offset(i_req.address);
    assign w_slow_lat = {1'b0, i_miss_penalty} + LAT_W'(1);

    always_comb begin
        w_fill_word = '0;
        if (int'(w_off) < FILL_FIELDS) begin
            w_fill_word = i_req.fill[w_off[FILL_IDX_W-1:0]];
        end
    end

    always_comb begin
        n_countdown     = r_countdown;
        n_load_pending  = r_load_pending;
        n_store_pending = r_store_pending;
        n_hits          = r_hits;
        n_misses        = r_misses;
        w_cmd           = '0;
        o_res           = '0;
        o_res.latency   = LAT_W'(1);

        case (i_req.op)
            OP_LOAD: begin
                if (i_lookup.hit) begin
                    n_hits          = r_hits + CNT_W'(1);
                    o_res.was_hit   = 1'b1;
                    o_res.load_data = i_lookup.hit_word;
                    w_cmd.lru_wr    = 1'b1;
                    w_cmd.way       = i_lookup.hit_way;
                end else begin
                    o_res.latency = w_slow_lat;
                    if (r_countdown == '0 && !r_load_pending) begin
                        n_misses       = r_misses + CNT_W'(1);
                        n_countdown    = i_miss_penalty;
                        n_load_pending = 1'b1;
                    end
                    if (n_countdown == '0) begin
                        w_cmd.fill       = 1'b1;
                        w_cmd.lru_wr     = 1'b1;
                        w_cmd.way        = i_lookup.victim_way;
                        n_load_pending   = 1'b0;
                        o_res.fill_taken = 1'b1;
                        o_res.load_data  = w_fill_word;
                    end else begin
                        n_countdown   = n_countdown - PEN_W'(1);
                        o_res.stalled = 1'b1;
                    end
                end
            end
            OP_STORE: begin
                o_res.was_hit = i_lookup.hit;
                o_res.latency = w_slow_lat;
                // On a hit, the line is updated on any attempt that finds no stall pending.
                if (r_countdown == '0 && i_lookup.hit) begin
                    w_cmd.word_wr = 1'b1;
                    w_cmd.lru_wr  = 1'b1;
                    w_cmd.way     = i_lookup.hit_way;
                end
                if (r_countdown == '0 && !r_store_pending) begin
                    if (i_lookup.hit) begin
                        n_hits = r_hits + CNT_W'(1);
                    end else begin
                        n_misses = r_misses + CNT_W'(1);
                    end
                    n_countdown     = i_miss_penalty;
                    n_store_pending = 1'b1;
                end
                if (n_countdown == '0) begin
                    n_store_pending         = 1'b0;
                    o_res.mem_write_valid   = 1'b1;
                    o_res.mem_write_address = i_req.address;
                    o_res.mem_write_value   = i_req.store_value;
                end else begin
                    n_countdown   = n_countdown - PEN_W'(1);
                    o_res.stalled = 1'b1;
                end
            end
            OP_FLUSH: begin
                w_cmd.flush = 1'b1;
                n_hits      = '0;
                n_misses    = '0;
            end
            default: begin
            end
        endcase

        o_res.hit_count  = n_hits;
        o_res.miss_count = n_misses;
        o_cmd = i_go ? w_cmd : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown     <= '0;
            r_load_pending  <= 1'b0;
            r_store_pending <= 1'b0;
            r_hits          <= '0;
            r_misses        <= '0;
        end else if (i_go) begin
            r_countdown     <= n_countdown;
            r_load_pending  <= n_load_pending;
            r_store_pending <= n_store_pending;
            r_hits          <= n_hits;
            r_misses        <= n_misses;
        end
    end

    a_fill_clears_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && (o_res.fill_taken || o_res.mem_write_valid)) |=> (r_countdown == '0))
        else $error("countdown not zero after a completed miss or store");

    a_fill_clears_load_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_res.fill_taken) |=> !r_load_pending)
        else $error("load still pending after a line fill");

    a_write_clears_store_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_res.mem_write_valid) |=> !r_store_pending)
        else $error("store still pending after its write-through");

endmodule

[hw/rtl/two_way_lru_cache_controller_core.sv]
// Top level of the two-way set-associative write-through cache controller.
// A result word passes from the input register through the tag compare into the result
// register, which it enters when the compare stage advances.
// Throughput: one request word per cycle while i_out_stall does not hold the result register.
// Reset (synchronous, active low) clears all lines, LRU bits, totals, countdown and
// pending flags, and sets the miss penalty to three; no clearing pass is needed.
module two_way_lru_cache_controller_core import twlc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_op,
    input  logic [ADDR_BITS-1:0]    i_address,
    input  logic signed [WORD_W-1:0] i_store_value,
    input  logic signed [WORD_W-1:0] i_fill_word0,
    input  logic signed [WORD_W-1:0] i_fill_word1,
    input  logic signed [WORD_W-1:0] i_fill_word2,
    input  logic signed [WORD_W-1:0] i_fill_word3,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_stalled,
    output logic signed [WORD_W-1:0] o_load_data,
    output logic                    o_was_hit,
    output logic [LAT_W-1:0]        o_latency,
    output logic                    o_fill_taken,
    output logic                    o_mem_write_valid,
    output logic [ADDR_BITS-1:0]    o_mem_write_address,
    output logic signed [WORD_W-1:0] o_mem_write_value,
    output logic [CNT_W-1:0]        o_hit_count,
    output logic [CNT_W-1:0]        o_miss_count,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // Input register: holds the accepted request word until the compare stage takes it.
    logic    r_in_valid;
    t_req    r_in;
    // Result register: holds a finished result word until the consumer takes it.
    logic    r_out_valid;
    t_result r_out;

    logic             w_accept;
    logic             w_go;
    logic [PEN_W-1:0] w_miss_penalty;
    t_lookup          w_lookup;
    t_arr_cmd         w_cmd;
    t_result          w_res;

    // The compare stage runs whenever it holds a word and the result register is
    // free or being emptied in this cycle, so a new word can enter every cycle.
    assign w_go       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_go;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.op          <= i_op;
            r_in.address     <= i_address;
            r_in.store_value <= i_store_value;
            r_in.fill[0]     <= i_fill_word0;
            r_in.fill[1]     <= i_fill_word1;
            r_in.fill[2]     <= i_fill_word2;
            r_in.fill[3]     <= i_fill_word3;
        end
        if (w_go) begin
            r_out <= w_res;
        end
    end

    twlc_apb u_apb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_miss_penalty (w_miss_penalty)
    );

    // Tag lookup and line updates for the word in the input register.
    twlc_array u_array (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_address     (r_in.address),
        .i_store_value (r_in.store_value),
        .i_fill        (r_in.fill),
        .i_cmd         (w_cmd),
        .o_lookup      (w_lookup)
    );

    // Stall sequencing and totals; the array update command is only issued when
    // the compare stage actually advances.
    twlc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (w_go),
        .i_req          (r_in),
        .i_miss_penalty (w_miss_penalty),
        .i_lookup       (w_lookup),
        .o_cmd          (w_cmd),
        .o_res          (w_res)
    );

    assign o_out_valid         = r_out_valid;
    assign o_stalled           = r_out.stalled;
    assign o_load_data         = r_out.load_data;
    assign o_was_hit           = r_out.was_hit;
    assign o_latency           = r_out.latency;
    assign o_fill_taken        = r_out.fill_taken;
    assign o_mem_write_valid   = r_out.mem_write_valid;
    assign o_mem_write_address = r_out.mem_write_address;
    assign o_mem_write_value   = r_out.mem_write_value;
    assign o_hit_count         = r_out.hit_count;
    assign o_miss_count        = r_out.miss_count;

    // A fill only ends a load miss, so that word is neither stalled nor a hit.
    a_fill_is_completed_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fill_taken) |-> (!o_stalled && !o_was_hit && !o_mem_write_valid))
        else $error("fill reported on a stalled or hitting access");

    // A write-through always ends the access.
    a_write_not_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mem_write_valid) |-> !o_stalled)
        else $error("write-through reported on a stalled access");

    // The compare stage never advances into a full, stalled result register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_go)
        else $error("result register overwritten while stalled");

endmodule
